// ===== rtl/core/pfa_pkg.sv =====
// Shared constants, codes and store request/response types of the page-frame allocator.
package pfa_pkg;

    localparam int NUM_FRAMES = 1024;
    localparam int FW         = $clog2(NUM_FRAMES);
    localparam int CW         = 11;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_USER   = 2'd0;
    localparam t_kind KIND_FREE   = 2'd1;
    localparam t_kind KIND_KERNEL = 2'd2;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_VICTIM = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_RUN = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BAD    = 2'd3;

    typedef struct packed {
        logic [FW-1:0] rd_addr;
        logic          meta_we;
        logic [FW-1:0] meta_addr;
        t_kind         meta_kind;
        logic          meta_in;
        logic          hn_we;
        logic [FW-1:0] hn_addr;
        logic          hn_d;
        logic          hp_we;
        logic [FW-1:0] hp_addr;
        logic          hp_d;
        logic          nxt_we;
        logic [FW-1:0] nxt_addr;
        logic [FW-1:0] nxt_d;
        logic          prv_we;
        logic [FW-1:0] prv_addr;
        logic [FW-1:0] prv_d;
        logic          rlen_we;
        logic [FW-1:0] rlen_addr;
        logic [CW-1:0] rlen_d;
    } t_store_req;

    typedef struct packed {
        t_kind         kind;
        logic          in_fifo;
        logic          hn;
        logic          hp;
        logic [FW-1:0] nxt;
        logic [FW-1:0] prv;
        logic [CW-1:0] rlen;
    } t_store_rsp;

endpackage

// ===== rtl/core/page_frame_allocator_fifo_victim.sv =====
// Top level of the page-frame allocator: APB registers, sequencer and frame tables.
//
// Page-frame table with first-fit run allocation and a FIFO list of swap victims.
// Issue a request by raising start while busy is low; busy then stays high until the
// result has been shown. Each request gives exactly one result, held on o_status,
// o_frame_index and o_must_evict for the single cycle in which o_valid is high; the
// receiver cannot stall it, so capture it on that cycle. After reset the block runs a
// clearing pass over all 1024 frame-table entries with busy high; register writes
// are taken during it. The sequencer walks the tables through one registered read
// port: allocate scans for a free run, then marks each frame of it, linking each
// swappable frame onto the tail of the victim list, and stores the run length; free
// reads the stored length unless a page count is given, then releases each frame;
// take-victim moves the head frame to the tail when the list holds more than one.
// Write reserved_frames and frame_count only while no request is outstanding.
module page_frame_allocator_fifo_victim (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_operation,
    input  logic [pfa_pkg::CW-1:0] i_page_count,
    input  logic                   i_kernel_page,
    input  logic                   i_pinned,
    input  logic [pfa_pkg::FW-1:0] i_frame,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [pfa_pkg::FW-1:0] o_frame_index,
    output logic                   o_must_evict
);
    import pfa_pkg::*;

    localparam logic REG_RESERVED = 1'b0;

    logic [CW-1:0] r_reserved, r_frame_count;
    logic [CW-1:0] w_hi;
    logic          w_start;
    t_store_req    w_req;
    t_store_rsp    w_rsp;

    // Write a register on the access cycle of an APB write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved    <= '0;
            r_frame_count <= CW'(NUM_FRAMES);
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_RESERVED) r_reserved <= pwdata[CW-1:0];
            else                          r_frame_count <= pwdata[CW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RESERVED) ? {{(32-CW){1'b0}}, r_reserved}
                                               : {{(32-CW){1'b0}}, r_frame_count};

    // Clip the managed range at the table depth.
    assign w_hi    = (r_frame_count > CW'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : r_frame_count;
    assign w_start = start && !busy;

    pfa_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_lo          (r_reserved),
        .i_hi          (w_hi),
        .i_start       (w_start),
        .i_operation   (i_operation),
        .i_page_count  (i_page_count),
        .i_kernel_page (i_kernel_page),
        .i_pinned      (i_pinned),
        .i_frame       (i_frame),
        .o_busy        (busy),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_frame_index (o_frame_index),
        .o_must_evict  (o_must_evict),
        .o_req         (w_req),
        .i_rsp         (w_rsp)
    );

    pfa_store u_store (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

endmodule

// ===== rtl/core/pfa_store.sv =====
// Per-frame tables: kind, links, link-valid bits and run length, one registered read address.
module pfa_store (
    input  logic                i_clk,
    input  pfa_pkg::t_store_req i_req,
    output pfa_pkg::t_store_rsp o_rsp
);
    import pfa_pkg::*;

    logic [2:0]    r_meta [NUM_FRAMES];
    logic          r_hn   [NUM_FRAMES];
    logic          r_hp   [NUM_FRAMES];
    logic [FW-1:0] r_nxt  [NUM_FRAMES];
    logic [FW-1:0] r_prv  [NUM_FRAMES];
    logic [CW-1:0] r_rlen [NUM_FRAMES];

    always_ff @(posedge i_clk) begin
        if (i_req.meta_we) r_meta[i_req.meta_addr] <= {i_req.meta_kind, i_req.meta_in};
        if (i_req.hn_we)   r_hn[i_req.hn_addr]     <= i_req.hn_d;
        if (i_req.hp_we)   r_hp[i_req.hp_addr]     <= i_req.hp_d;
        if (i_req.nxt_we)  r_nxt[i_req.nxt_addr]   <= i_req.nxt_d;
        if (i_req.prv_we)  r_prv[i_req.prv_addr]   <= i_req.prv_d;
        if (i_req.rlen_we) r_rlen[i_req.rlen_addr] <= i_req.rlen_d;
    end

    always_ff @(posedge i_clk) begin
        o_rsp.kind    <= r_meta[i_req.rd_addr][2:1];
        o_rsp.in_fifo <= r_meta[i_req.rd_addr][0];
        o_rsp.hn      <= r_hn[i_req.rd_addr];
        o_rsp.hp      <= r_hp[i_req.rd_addr];
        o_rsp.nxt     <= r_nxt[i_req.rd_addr];
        o_rsp.prv     <= r_prv[i_req.rd_addr];
        o_rsp.rlen    <= r_rlen[i_req.rd_addr];
    end

endmodule

// ===== rtl/core/pfa_seq.sv =====
// Sequencer that walks the frame tables one step at a time for allocate, free and victim.
module pfa_seq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [pfa_pkg::CW-1:0]  i_lo,
    input  logic [pfa_pkg::CW-1:0]  i_hi,
    input  logic                    i_start,
    input  logic [1:0]              i_operation,
    input  logic [pfa_pkg::CW-1:0]  i_page_count,
    input  logic                    i_kernel_page,
    input  logic                    i_pinned,
    input  logic [pfa_pkg::FW-1:0]  i_frame,
    output logic                    o_busy,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic [pfa_pkg::FW-1:0]  o_frame_index,
    output logic                    o_must_evict,
    output pfa_pkg::t_store_req     o_req,
    input  pfa_pkg::t_store_rsp     i_rsp
);
    import pfa_pkg::*;

    typedef enum logic [12:0] {
        S_CLR  = 13'b0000000000001,
        S_IDLE = 13'b0000000000010,
        S_ARD  = 13'b0000000000100,
        S_ACHK = 13'b0000000001000,
        S_MA   = 13'b0000000010000,
        S_MB   = 13'b0000000100000,
        S_MRL  = 13'b0000001000000,
        S_FRD  = 13'b0000010000000,
        S_FLEN = 13'b0000100000000,
        S_URD  = 13'b0001000000000,
        S_UA   = 13'b0010000000000,
        S_UB   = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic [FW-1:0] r_clr, n_clr;
    logic [FW-1:0] r_head, n_head, r_tail, n_tail;
    logic [CW-1:0] r_size, n_size;
    logic [CW-1:0] r_i, n_i, r_cnt, n_cnt, r_np, n_np, r_end, n_end;
    logic [FW-1:0] r_first, n_first, r_fr, n_fr, r_idx, n_idx;
    logic [1:0]    r_op, n_op, r_status, n_status;
    logic          r_kern, n_kern, r_pin, n_pin, r_pfree, n_pfree, r_swap, n_swap;

    logic          w_swp;
    logic [CW-1:0] w_cnt, w_len, w_sz, w_inc;
    logic [FW-1:0] w_first;
    logic [CW:0]   w_end;

    assign w_swp = (r_op == OP_VICTIM) || (!r_kern && !r_pin);
    assign w_inc = r_i + CW'(1);

    always_comb begin
        n_state = r_state; n_clr = r_clr; n_head = r_head; n_tail = r_tail;
        n_size = r_size; n_i = r_i; n_cnt = r_cnt; n_np = r_np; n_end = r_end;
        n_first = r_first; n_fr = r_fr; n_idx = r_idx; n_op = r_op;
        n_status = r_status; n_kern = r_kern; n_pin = r_pin; n_pfree = r_pfree;
        n_swap = r_swap;
        w_cnt = '0; w_first = '0; w_len = '0; w_end = '0; w_sz = '0;
        o_req = '0;
        o_req.rd_addr = r_i[FW-1:0];
        unique case (r_state)
            S_CLR: begin
                o_req.meta_we   = 1'b1;
                o_req.meta_addr = r_clr;
                o_req.meta_kind = KIND_FREE;
                o_req.hn_we     = 1'b1;
                o_req.hn_addr   = r_clr;
                o_req.hp_we     = 1'b1;
                o_req.hp_addr   = r_clr;
                n_clr = r_clr + FW'(1);
                if (r_clr == FW'(NUM_FRAMES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_op = i_operation; n_np = i_page_count; n_kern = i_kernel_page;
                    n_pin = i_pinned; n_fr = i_frame;
                    n_status = ST_BAD; n_idx = '0; n_swap = 1'b0;
                    n_state = S_DONE;
                    unique case (i_operation)
                        OP_ALLOC: begin
                            if (i_page_count != '0) begin
                                n_i = i_lo;
                                n_pfree = 1'b0;
                                if (i_lo < i_hi) begin
                                    n_state = S_ARD;
                                end else begin
                                    n_status = ST_NO_RUN;
                                    n_swap   = !i_kernel_page;
                                end
                            end
                        end
                        OP_FREE: begin
                            if ({1'b0, i_frame} >= i_lo && {1'b0, i_frame} < i_hi) begin
                                n_i = {1'b0, i_frame};
                                n_state = S_FRD;
                            end
                        end
                        OP_VICTIM: begin
                            if (r_size == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_status = ST_OK;
                                n_idx = r_head;
                                if (r_size != CW'(1)) begin
                                    n_i = {1'b0, r_head};
                                    n_state = S_URD;
                                end
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_ARD: n_state = S_ACHK;
            S_ACHK: begin
                // extend or restart the current free run
                w_cnt   = r_pfree ? r_cnt + CW'(1) : CW'(1);
                w_first = r_pfree ? r_first : r_i[FW-1:0];
                if (i_rsp.kind == KIND_FREE && w_cnt >= r_np) begin
                    n_first = w_first;
                    n_i     = {1'b0, w_first};
                    n_cnt   = r_np;
                    n_state = w_swp ? S_MA : S_MB;
                end else begin
                    n_pfree = (i_rsp.kind == KIND_FREE);
                    n_cnt   = w_cnt;
                    n_first = w_first;
                    n_i     = w_inc;
                    if (w_inc < i_hi) begin
                        n_state = S_ARD;
                    end else begin
                        n_status = ST_NO_RUN;
                        n_swap   = !r_kern;
                        n_state  = S_DONE;
                    end
                end
            end
            S_MA: begin
                if (r_size != '0) begin
                    o_req.nxt_we   = 1'b1;
                    o_req.nxt_addr = r_tail;
                    o_req.nxt_d    = r_i[FW-1:0];
                    o_req.hn_we    = 1'b1;
                    o_req.hn_addr  = r_tail;
                    o_req.hn_d     = 1'b1;
                end
                n_state = S_MB;
            end
            S_MB: begin
                o_req.meta_we   = 1'b1;
                o_req.meta_addr = r_i[FW-1:0];
                o_req.meta_kind = (r_op != OP_VICTIM && r_kern) ? KIND_KERNEL : KIND_USER;
                o_req.meta_in   = w_swp;
                o_req.hn_we     = 1'b1;
                o_req.hn_addr   = r_i[FW-1:0];
                o_req.hp_we     = 1'b1;
                o_req.hp_addr   = r_i[FW-1:0];
                o_req.hp_d      = w_swp && (r_size != '0);
                o_req.prv_we    = w_swp && (r_size != '0);
                o_req.prv_addr  = r_i[FW-1:0];
                o_req.prv_d     = r_tail;
                if (w_swp) begin
                    if (r_size == '0) n_head = r_i[FW-1:0];
                    n_tail = r_i[FW-1:0];
                    n_size = r_size + CW'(1);
                end
                if (r_op == OP_VICTIM) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        n_state = S_MRL;
                    end else begin
                        n_i = w_inc;
                        n_state = w_swp ? S_MA : S_MB;
                    end
                end
            end
            S_MRL: begin
                o_req.rlen_we   = 1'b1;
                o_req.rlen_addr = r_first;
                o_req.rlen_d    = r_np;
                n_status = ST_OK;
                n_idx    = r_first;
                n_state  = S_DONE;
            end
            S_FRD: n_state = S_FLEN;
            S_FLEN: begin
                w_len = (r_np != '0) ? r_np : i_rsp.rlen;
                w_end = {1'b0, r_i} + {1'b0, w_len};
                n_end = (w_end > {1'b0, i_hi}) ? i_hi : w_end[CW-1:0];
                n_status = ST_OK;
                n_idx = r_fr;
                n_state = (w_len == '0) ? S_DONE : S_URD;
            end
            S_URD: n_state = S_UA;
            S_UA: begin
                if (i_rsp.in_fifo) begin
                    if (i_rsp.hp) begin
                        o_req.nxt_we   = 1'b1;
                        o_req.nxt_addr = i_rsp.prv;
                        o_req.nxt_d    = i_rsp.nxt;
                        o_req.hn_we    = 1'b1;
                        o_req.hn_addr  = i_rsp.prv;
                        o_req.hn_d     = i_rsp.hn;
                    end else if (i_rsp.hn) begin
                        n_head = i_rsp.nxt;
                    end
                    if (i_rsp.hn) begin
                        o_req.prv_we   = 1'b1;
                        o_req.prv_addr = i_rsp.nxt;
                        o_req.prv_d    = i_rsp.prv;
                        o_req.hp_we    = 1'b1;
                        o_req.hp_addr  = i_rsp.nxt;
                        o_req.hp_d     = i_rsp.hp;
                    end else if (i_rsp.hp) begin
                        n_tail = i_rsp.prv;
                    end
                    w_sz = (r_size != '0) ? r_size - CW'(1) : r_size;
                    n_size = w_sz;
                    if (w_sz == '0) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                end
                n_state = S_UB;
            end
            S_UB: begin
                o_req.meta_we   = 1'b1;
                o_req.meta_addr = r_i[FW-1:0];
                o_req.meta_kind = (r_op == OP_FREE) ? KIND_FREE : KIND_USER;
                o_req.hn_we     = 1'b1;
                o_req.hn_addr   = r_i[FW-1:0];
                o_req.hp_we     = 1'b1;
                o_req.hp_addr   = r_i[FW-1:0];
                if (r_op == OP_VICTIM) begin
                    n_state = S_MA;
                end else begin
                    n_i = w_inc;
                    n_state = (w_inc < r_end) ? S_URD : S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_size  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_size  <= n_size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_cnt <= n_cnt; r_np <= n_np; r_end <= n_end;
        r_first <= n_first; r_fr <= n_fr; r_idx <= n_idx; r_op <= n_op;
        r_status <= n_status; r_kern <= n_kern; r_pin <= n_pin;
        r_pfree <= n_pfree; r_swap <= n_swap;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_DONE);
    assign o_status      = r_status;
    assign o_frame_index = r_idx;
    assign o_must_evict  = r_swap;

endmodule

// ===== tb/pfa_frame_checker.sv =====
// Checker for the page-frame allocator: tracks registers, predicts each result, compares.
module pfa_frame_checker
    import pfa_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic          pready,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    input  logic          start,
    input  logic          busy,
    input  logic [1:0]    i_operation,
    input  logic [CW-1:0] i_page_count,
    input  logic          i_kernel_page,
    input  logic          i_pinned,
    input  logic [FW-1:0] i_frame,
    input  logic          o_valid,
    input  logic [1:0]    o_status,
    input  logic [FW-1:0] o_frame_index,
    input  logic          o_must_evict,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_checked
);

    localparam logic CFG_RESERVED = 1'b0;
    localparam logic CFG_FRAMES   = 1'b1;

    typedef struct packed {
        logic [1:0]    status;
        logic [FW-1:0] frame_index;
        logic          must_evict;
    } t_outcome;

    t_outcome outcome_q[$];

    int unsigned   reserved_r, frames_r;
    t_kind         kind_m[NUM_FRAMES];
    logic [CW-1:0] rlen_m[NUM_FRAMES];
    logic [FW-1:0] nxt_m[NUM_FRAMES];
    logic [FW-1:0] prv_m[NUM_FRAMES];
    bit            hn_m[NUM_FRAMES];
    bit            hp_m[NUM_FRAMES];
    bit            listed_m[NUM_FRAMES];
    int unsigned   head_r, tail_r, size_r;

    function automatic void victim_append(int unsigned f);
        if (size_r == 0) begin
            head_r = f;
            hp_m[f] = 0;
        end else begin
            nxt_m[tail_r] = FW'(f);
            hn_m[tail_r] = 1;
            prv_m[f] = FW'(tail_r);
            hp_m[f] = 1;
        end
        hn_m[f] = 0;
        tail_r = f;
        listed_m[f] = 1;
        size_r++;
    endfunction

    function automatic void victim_unlink(int unsigned f);
        int unsigned p, n;
        p = prv_m[f];
        n = nxt_m[f];
        if (!listed_m[f]) return;
        if (hp_m[f]) begin
            nxt_m[p] = FW'(n);
            hn_m[p] = hn_m[f];
        end else if (hn_m[f]) begin
            head_r = n;
        end
        if (hn_m[f]) begin
            prv_m[n] = FW'(p);
            hp_m[n] = hp_m[f];
        end else if (hp_m[f]) begin
            tail_r = p;
        end
        hn_m[f] = 0;
        hp_m[f] = 0;
        listed_m[f] = 0;
        if (size_r > 0) size_r--;
        if (size_r == 0) begin
            head_r = 0;
            tail_r = 0;
        end
    endfunction

    // Apply one request to the frame table and return what the block must answer.
    function automatic t_outcome apply_request(logic [1:0] op, int unsigned np, bit kern,
                                               bit pin, int unsigned fr);
        t_outcome    res;
        int unsigned hi, lo, first, stop, n;
        bit          found;
        res = '{status: ST_BAD, frame_index: '0, must_evict: 1'b0};
        hi = (frames_r < NUM_FRAMES) ? frames_r : NUM_FRAMES;
        lo = reserved_r;
        first = 0;
        found = 0;
        case (op)
            OP_ALLOC: begin
                if (np != 0) begin
                    for (int unsigned i = lo; i < hi && !found; i++) begin
                        if (kind_m[i] == KIND_FREE) begin
                            if (i == lo || kind_m[i-1] != KIND_FREE) first = i;
                            if (i - first + 1 >= np) found = 1;
                        end
                    end
                    if (found) begin
                        for (int unsigned i = first; i < first + np; i++) begin
                            kind_m[i] = kern ? KIND_KERNEL : KIND_USER;
                            if (!kern && !pin) begin
                                victim_append(i);
                            end else begin
                                hn_m[i] = 0;
                                hp_m[i] = 0;
                                listed_m[i] = 0;
                            end
                        end
                        rlen_m[first] = CW'(np);
                        res.status = ST_OK;
                        res.frame_index = FW'(first);
                    end else begin
                        res.status = ST_NO_RUN;
                        res.must_evict = !kern;
                    end
                end
            end
            OP_FREE: begin
                if (fr >= lo && fr < hi) begin
                    n = (np != 0) ? np : rlen_m[fr];
                    stop = fr + n;
                    if (stop > hi) stop = hi;
                    for (int unsigned i = fr; i < stop; i++) begin
                        kind_m[i] = KIND_FREE;
                        victim_unlink(i);
                    end
                    res.status = ST_OK;
                    res.frame_index = FW'(fr);
                end
            end
            OP_VICTIM: begin
                if (size_r == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    n = head_r;
                    if (size_r > 1) begin
                        victim_unlink(n);
                        victim_append(n);
                    end
                    res.status = ST_OK;
                    res.frame_index = FW'(n);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want, got;
        if (!i_rst_n) begin
            reserved_r <= 0;
            frames_r   <= 1024;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                kind_m[i] = KIND_FREE;
                rlen_m[i] = '0;
                nxt_m[i] = '0;
                prv_m[i] = '0;
                hn_m[i] = 0;
                hp_m[i] = 0;
                listed_m[i] = 0;
            end
            head_r = 0;
            tail_r = 0;
            size_r = 0;
            outcome_q.delete();
            o_fail_count <= 0;
            o_checked <= 0;
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == CFG_RESERVED)    reserved_r <= pwdata[10:0];
                else if (paddr[2] == CFG_FRAMES) frames_r   <= pwdata[10:0];
            end
            // Compare before predicting; a result never shares a cycle with its own request.
            if (o_valid) begin
                got = '{status: o_status, frame_index: o_frame_index,
                        must_evict: o_must_evict};
                if (outcome_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: result with nothing pending: status %0d frame %0d",
                                 o_status, o_frame_index);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = outcome_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("ERROR: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.status, want.frame_index, want.must_evict,
                                     got.status, got.frame_index, got.must_evict);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                outcome_q.push_back(apply_request(i_operation, i_page_count, i_kernel_page,
                                                  i_pinned, i_frame));
            o_pending <= outcome_q.size();
        end
    end

endmodule

// ===== tb/page_frame_allocator_fifo_victim_test.sv =====
// Stimulus and verdict for the page-frame allocator testbench.
module page_frame_allocator_fifo_victim_test;
    import pfa_pkg::*;

    // Byte addresses of the two registers.
    localparam logic [2:0] ADDR_RESERVED = 3'd0;
    localparam logic [2:0] ADDR_FRAMES   = 3'd4;
    localparam int         NUM_PHASES    = 5;
    // Operation code with no meaning; the block must reject it.
    localparam logic [1:0] OP_UNDEFINED  = 2'd3;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          start = 1'b0;
    logic          busy;
    logic [1:0]    i_operation = OP_ALLOC;
    logic [CW-1:0] i_page_count = '0;
    logic          i_kernel_page = 1'b0;
    logic          i_pinned = 1'b0;
    logic [FW-1:0] i_frame = '0;
    logic          o_valid;
    logic [1:0]    o_status;
    logic [FW-1:0] o_frame_index;
    logic          o_must_evict;
    int            fail_count, pending, checked;

    // Bookkeeping of what was handed out, so frees can be well formed.
    int unsigned   run_start_q[$];
    int unsigned   run_len_q[$];
    bit            run_started[NUM_FRAMES];
    int unsigned   started_q[$];
    int            gap_pct;
    int            requests_sent;

    page_frame_allocator_fifo_victim dut (.*);

    pfa_frame_checker u_checker (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .start, .busy, .i_operation, .i_page_count, .i_kernel_page, .i_pinned, .i_frame,
        .o_valid, .o_status, .o_frame_index, .o_must_evict,
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #(64'd12 * 64'd20_000_000);
        $display("timeout");
        $display("FAIL page_frame_allocator_fifo_victim");
        $finish;
    end

    // Register write: a setup phase, then an access phase.
    task automatic reg_write(logic [2:0] addr, int unsigned value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Issue one request, hold it until taken, then wait for its single result.
    task automatic send_request(logic [1:0] op, int unsigned np, bit kern, bit pin,
                                int unsigned fr);
        while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        @(posedge i_clk);
        start         <= 1'b1;
        i_operation   <= op;
        i_page_count  <= CW'(np);
        i_kernel_page <= kern;
        i_pinned      <= pin;
        i_frame       <= FW'(fr);
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        start <= 1'b0;
        requests_sent++;
        do @(negedge i_clk); while (!o_valid);
        // Remember successful allocations for later frees.
        if (op == OP_ALLOC && o_status == ST_OK) begin
            run_start_q.push_back(o_frame_index);
            run_len_q.push_back(np);
            if (!run_started[o_frame_index]) begin
                run_started[o_frame_index] = 1;
                started_q.push_back(o_frame_index);
            end
        end
    endtask

    // Wait until every request has been answered.
    task automatic drain;
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_request;
        int unsigned r, k, np;
        r = $urandom_range(99);
        if (r < 45) begin
            if ($urandom_range(49) == 0)      np = 0;
            else if ($urandom_range(19) == 0) np = $urandom_range(1024, 1);
            else                              np = $urandom_range(8, 1);
            send_request(OP_ALLOC, np, $urandom_range(3) == 0, $urandom_range(3) == 0,
                         $urandom_range(1023));
        end else if (r < 75) begin
            if (run_start_q.size() != 0 && $urandom_range(99) < 80) begin
                // Release a run that was handed out, by stored or exact length.
                k = $urandom_range(run_start_q.size() - 1);
                np = ($urandom_range(1) == 1) ? 0 : run_len_q[k];
                send_request(OP_FREE, np, $urandom_range(1) == 1, $urandom_range(1) == 1,
                             run_start_q[k]);
                run_start_q.delete(k);
                run_len_q.delete(k);
            end else if (started_q.size() != 0 && $urandom_range(3) == 0) begin
                send_request(OP_FREE, 0, $urandom_range(1) == 1, $urandom_range(1) == 1,
                             started_q[$urandom_range(started_q.size() - 1)]);
            end else begin
                np = ($urandom_range(9) == 0) ? $urandom_range(1024, 1) : $urandom_range(6, 1);
                send_request(OP_FREE, np, $urandom_range(1) == 1, $urandom_range(1) == 1,
                             $urandom_range(1023));
            end
        end else if (r < 95) begin
            send_request(OP_VICTIM, $urandom_range(1024), $urandom_range(1) == 1,
                         $urandom_range(1) == 1, $urandom_range(1023));
        end else begin
            send_request(OP_UNDEFINED, $urandom_range(1024), $urandom_range(1) == 1,
                         $urandom_range(1) == 1, $urandom_range(1023));
        end
    endtask

    initial begin
        int unsigned res_set[NUM_PHASES] = '{0, 16, 0, 1024, 40};
        int unsigned fc_set[NUM_PHASES]  = '{1024, 96, 1, 1024, 1024};
        int          cnt_set[NUM_PHASES] = '{200, 150, 60, 20, 150};
        int          wait_cycles;
        gap_pct = 0;
        requests_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers may be written during the clearing pass.
        reg_write(ADDR_RESERVED, 0);
        reg_write(ADDR_FRAMES, 1024);

        // Directed: bad codes, empty list, whole-table runs, clipping, already-free frames.
        send_request(OP_UNDEFINED, 1024, 1, 1, 1023);
        send_request(OP_ALLOC, 0, 0, 0, 0);
        send_request(OP_VICTIM, 0, 0, 0, 0);
        send_request(OP_ALLOC, 1024, 0, 0, 0);
        send_request(OP_VICTIM, 0, 0, 0, 0);
        send_request(OP_VICTIM, 0, 0, 0, 0);
        send_request(OP_ALLOC, 1, 1, 0, 0);
        send_request(OP_FREE, 1024, 0, 0, 0);
        send_request(OP_ALLOC, 1, 0, 0, 0);
        send_request(OP_VICTIM, 0, 0, 0, 0);
        send_request(OP_ALLOC, 3, 1, 1, 0);
        send_request(OP_ALLOC, 2, 0, 1, 0);
        send_request(OP_ALLOC, 1024, 1, 0, 0);
        send_request(OP_ALLOC, 1024, 0, 1, 0);
        send_request(OP_FREE, 0, 0, 0, 1);
        send_request(OP_FREE, 4, 0, 0, 500);
        send_request(OP_FREE, 8, 1, 1, 1023);
        send_request(OP_FREE, 1, 0, 0, 0);
        drain();
        reg_write(ADDR_RESERVED, 1000);
        reg_write(ADDR_FRAMES, 1010);
        send_request(OP_FREE, 1, 0, 0, 5);
        send_request(OP_FREE, 1, 0, 0, 1015);
        send_request(OP_ALLOC, 12, 0, 0, 0);
        send_request(OP_ALLOC, 3, 0, 0, 0);
        send_request(OP_FREE, 5, 0, 0, 1009);
        send_request(OP_VICTIM, 0, 0, 0, 0);

        // Random phases over several register settings and idling rates.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            reg_write(ADDR_RESERVED, res_set[p]);
            reg_write(ADDR_FRAMES, fc_set[p]);
            for (int n = 0; n < cnt_set[p]; n++) begin
                gap_pct = (p < 2) ? 22 : (p < 4) ? 69 : 0;
                // Let stretches run back to back now and then.
                if ((n / 25) % 3 == 2) gap_pct = 0;
                random_request();
            end
        end

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (50) @(posedge i_clk);
        $display("covered %0d requests over %0d register settings", requests_sent,
                 NUM_PHASES + 2);
        $display("checked %0d results, %0d still pending", checked, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS page_frame_allocator_fifo_victim");
        end else begin
            $display("FAIL page_frame_allocator_fifo_victim");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pfa_pkg.sv
rtl/core/pfa_store.sv
rtl/core/pfa_seq.sv
rtl/core/page_frame_allocator_fifo_victim.sv
tb/pfa_frame_checker.sv
tb/page_frame_allocator_fifo_victim_test.sv
